FILE: src/sqte_pkg.sv
// Shared types, constants and helpers for the SARSA Q-table engine.
// No dependencies; used by every module under src.
`default_nettype none

package sqte_pkg;

  // Table geometry defaults
  localparam int ROW_COUNT_DEF    = 12288;
  localparam int ACTION_COUNT_DEF = 16;

  // Fixed field widths
  localparam int ROW_W   = 14;
  localparam int ACT_W   = 4;
  localparam int Q16_W   = 17;
  localparam int VAL_W   = 32;

  // Datapath widths of the shared multiplier and the adders around it
  localparam int OPA_W   = 18;              // Q1.16 factor, zero extended
  localparam int TD_W    = 34;              // reward + gamma*q' - q
  localparam int PROD_W  = OPA_W + TD_W;    // full product
  localparam int NV_W    = 37;              // q + alpha*td before saturation
  localparam int FRAC_SH = 16;

  localparam logic [Q16_W-1:0] ONE_Q16          = 17'd65536;
  localparam logic [Q16_W-1:0] LEARN_RATE_RESET = 17'd13107;
  localparam logic [Q16_W-1:0] DISCOUNT_RESET   = 17'd64881;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'b1;

  // Request kinds
  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [ROW_W-1:0]        state_index;
    logic [ACT_W-1:0]        taken_action;
    logic [ROW_W-1:0]        next_state_index;
    logic [ACT_W-1:0]        succ_action;
    logic signed [VAL_W-1:0] reward;
    logic [Q16_W-1:0]        explore_level;
    logic [Q16_W-1:0]        random_fraction;
    logic [ACT_W-1:0]        random_action;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]        chosen_action;
    logic                    explored;
    logic signed [VAL_W-1:0] new_value;
  } rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_SCAN,
    ST_DRAIN,
    ST_RD_Q,
    ST_RD_QN,
    ST_MUL_G,
    ST_TD,
    ST_MUL_A,
    ST_WB,
    ST_DONE
  } sqte_state_t;

  // Factors above 1.0 saturate to 1.0
  function automatic logic [Q16_W-1:0] clamp_one(input logic [Q16_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/sqte_qmem.sv
// Q-table storage: single-port RAM, one write or one read per cycle,
// registered read data. Depends on sqte_pkg for the data width.
`default_nettype none

module sqte_qmem #(
  parameter int DEPTH  = sqte_pkg::ROW_COUNT_DEF * sqte_pkg::ACTION_COUNT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [ADDR_W-1:0]              addr,
  input  wire logic [sqte_pkg::VAL_W-1:0]     wdata,
  output logic      [sqte_pkg::VAL_W-1:0]     rdata
);

  logic [sqte_pkg::VAL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/sqte_mul.sv
// Shared signed multiplier with a registered product, used for both
// gamma*q' and alpha*td. Depends on sqte_pkg for operand widths.
`default_nettype none

module sqte_mul (
  input  wire logic                                clk,
  input  wire logic signed [sqte_pkg::OPA_W-1:0]   op_a,
  input  wire logic signed [sqte_pkg::TD_W-1:0]    op_b,
  output logic      signed [sqte_pkg::PROD_W-1:0]  prod
);

  // One multiply per cycle, product registered
  always_ff @(posedge clk) begin
    prod <= sqte_pkg::PROD_W'(op_a) * sqte_pkg::PROD_W'(op_b);
  end

endmodule

`default_nettype wire

FILE: src/sarsa_q_table_engine_core.sv
// SARSA Q-table engine top level: sequencer, datapath registers and output stage.
// Depends on sqte_pkg, sqte_qmem and sqte_mul.
//
// Usage:
//  - Request channel (in_valid/in_stall/in_data): a request is taken when in_valid
//    is high and in_stall low. in_stall stays high while a request is in work, so
//    one request is handled at a time.
//  - A select request reads the state's row one entry per cycle from the table RAM
//    and keeps the first maximum; the single RAM read port sets this rate.
//  - An update request reads q and q', then runs gamma*q' and alpha*td through the
//    one shared multiplier and writes the saturated result back if q is in the table.
//  - Response channel (out_valid/out_stall/out_data): a registered output stage.
//    The engine may take the next request while a response still waits; a finished
//    response is held in the sequencer until the output register is free.
//  - Configuration (cfg_we/cfg_index/cfg_data) is to be written by the user only
//    while idle; the block does not enforce it. alpha and gamma above 1.0 act as 1.0.
//  - After reset the table RAM is cleared one entry per cycle, ROW_COUNT * ACTION_COUNT
//    entries in all (196608 by default); in_stall is high meanwhile.
`default_nettype none

module sarsa_q_table_engine_core #(
  parameter int ROW_COUNT    = sqte_pkg::ROW_COUNT_DEF,
  parameter int ACTION_COUNT = sqte_pkg::ACTION_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire sqte_pkg::req_t                     in_data,
  // response channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output sqte_pkg::rsp_t                          out_data,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [sqte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sqte_pkg::Q16_W-1:0]         cfg_data
);

  localparam int DEPTH  = ROW_COUNT * ACTION_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(ACTION_COUNT);
  localparam int VAL_W  = sqte_pkg::VAL_W;

  sqte_pkg::sqte_state_t state, state_next;

  // Configuration registers
  logic [sqte_pkg::Q16_W-1:0] learn_rate;
  logic [sqte_pkg::Q16_W-1:0] discount;

  // Request registers
  sqte_pkg::req_t   req;
  logic             row_s_ok;
  logic             q_ok;
  logic             qn_ok;
  logic [ADDR_W-1:0] base_s;
  logic [ADDR_W-1:0] base_ns;

  // Sweep and scan counters
  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  scan_col;
  logic [COL_W-1:0]  scan_col_d;
  logic              scan_vld;

  // Datapath registers
  logic signed [VAL_W-1:0]            best;
  logic [COL_W-1:0]                   best_a;
  logic signed [VAL_W-1:0]            q_reg;
  logic signed [sqte_pkg::TD_W-1:0]   td;
  logic signed [VAL_W-1:0]            res_value;

  // RAM and multiplier signals
  logic                               mem_we;
  logic [ADDR_W-1:0]                  mem_addr;
  logic [VAL_W-1:0]                   mem_wdata;
  logic [VAL_W-1:0]                   mem_rdata;
  logic signed [sqte_pkg::OPA_W-1:0]  mul_a;
  logic signed [sqte_pkg::TD_W-1:0]   mul_b;
  logic signed [sqte_pkg::PROD_W-1:0] prod;
  logic signed [sqte_pkg::PROD_W-1:0] prod_sh;

  logic                               in_acc;
  logic                               out_load;
  logic                               clr_last;
  logic                               scan_last;

  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == sqte_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign scan_last = (scan_col == COL_W'(ACTION_COUNT - 1));
  assign prod_sh   = prod >>> sqte_pkg::FRAC_SH;

  sqte_qmem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_qmem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  sqte_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Random action reduced modulo the action count
  logic [sqte_pkg::ACT_W-1:0] ra_mod_tab [2**sqte_pkg::ACT_W];
  for (genvar i = 0; i < 2**sqte_pkg::ACT_W; i++) begin : g_ra_mod
    localparam int MODV = i % ACTION_COUNT;
    assign ra_mod_tab[i] = sqte_pkg::ACT_W'(MODV);
  end

  // Table entries outside the table read as zero
  logic signed [VAL_W-1:0] scan_val;
  logic signed [VAL_W-1:0] q_rd;
  logic signed [VAL_W-1:0] qn_rd;
  assign scan_val = row_s_ok ? signed'(mem_rdata) : '0;
  assign q_rd     = q_ok     ? signed'(mem_rdata) : '0;
  assign qn_rd    = qn_ok    ? signed'(mem_rdata) : '0;

  // TD error and new value
  logic signed [sqte_pkg::TD_W-1:0] td_next;
  logic signed [sqte_pkg::NV_W-1:0] nv_wide;
  logic signed [VAL_W-1:0]          nv_sat;
  assign td_next = sqte_pkg::TD_W'(req.reward) + sqte_pkg::TD_W'(prod_sh)
                 - sqte_pkg::TD_W'(q_reg);
  assign nv_wide = sqte_pkg::NV_W'(q_reg) + sqte_pkg::NV_W'(prod_sh);

  // Saturate to the signed 32-bit range
  always_comb begin
    if (nv_wide[sqte_pkg::NV_W-1:VAL_W-1] == '0 ||
        nv_wide[sqte_pkg::NV_W-1:VAL_W-1] == '1) begin
      nv_sat = nv_wide[VAL_W-1:0];
    end else if (nv_wide[sqte_pkg::NV_W-1]) begin
      nv_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      nv_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sqte_pkg::ST_CLEAR: if (clr_last) state_next = sqte_pkg::ST_IDLE;
      sqte_pkg::ST_IDLE:  if (in_acc) state_next = sqte_pkg::ST_BASE;
      sqte_pkg::ST_BASE: begin
        state_next = (req.req_type == sqte_pkg::REQ_UPDATE) ? sqte_pkg::ST_RD_Q
                                                          : sqte_pkg::ST_SCAN;
      end
      sqte_pkg::ST_SCAN:  if (scan_last) state_next = sqte_pkg::ST_DRAIN;
      sqte_pkg::ST_DRAIN: state_next = sqte_pkg::ST_DONE;
      sqte_pkg::ST_RD_Q:  state_next = sqte_pkg::ST_RD_QN;
      sqte_pkg::ST_RD_QN: state_next = sqte_pkg::ST_MUL_G;
      sqte_pkg::ST_MUL_G: state_next = sqte_pkg::ST_TD;
      sqte_pkg::ST_TD:    state_next = sqte_pkg::ST_MUL_A;
      sqte_pkg::ST_MUL_A: state_next = sqte_pkg::ST_WB;
      sqte_pkg::ST_WB:    state_next = sqte_pkg::ST_DONE;
      sqte_pkg::ST_DONE:  if (out_load) state_next = sqte_pkg::ST_IDLE;
      default:            state_next = sqte_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM port, multiplier operands, request stall
  always_comb begin
    in_stall  = (state != sqte_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_addr  = base_s + ADDR_W'(req.taken_action);
    mem_wdata = nv_sat;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      sqte_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      sqte_pkg::ST_SCAN:  mem_addr = base_s + ADDR_W'(scan_col);
      sqte_pkg::ST_RD_QN: mem_addr = base_ns + ADDR_W'(req.succ_action);
      sqte_pkg::ST_MUL_G: begin
        mul_a = signed'({1'b0, sqte_pkg::clamp_one(discount)});
        mul_b = sqte_pkg::TD_W'(qn_rd);
      end
      sqte_pkg::ST_MUL_A: begin
        mul_a = signed'({1'b0, sqte_pkg::clamp_one(learn_rate)});
        mul_b = td;
      end
      sqte_pkg::ST_WB:    mem_we = q_ok;
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sqte_pkg::ST_CLEAR;
      clr_addr   <= '0;
      scan_col   <= '0;
      scan_vld   <= 1'b0;
      out_valid  <= 1'b0;
      learn_rate <= sqte_pkg::LEARN_RATE_RESET;
      discount   <= sqte_pkg::DISCOUNT_RESET;
    end else begin
      state    <= state_next;
      scan_vld <= (state == sqte_pkg::ST_SCAN);
      if (state == sqte_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == sqte_pkg::ST_SCAN) begin
        scan_col <= scan_last ? '0 : scan_col + COL_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sqte_pkg::CFG_LEARN_RATE: learn_rate <= cfg_data;
          sqte_pkg::CFG_DISCOUNT:   discount   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Request capture and table bounds checks
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req      <= in_data;
      row_s_ok <= 32'(in_data.state_index) < 32'(ROW_COUNT);
      q_ok     <= (32'(in_data.state_index) < 32'(ROW_COUNT))
               && (32'(in_data.taken_action) < 32'(ACTION_COUNT));
      qn_ok    <= (32'(in_data.next_state_index) < 32'(ROW_COUNT))
               && (32'(in_data.succ_action) < 32'(ACTION_COUNT));
    end
    if (state == sqte_pkg::ST_BASE) begin
      base_s  <= ADDR_W'(ADDR_W'(req.state_index) * ADDR_W'(ACTION_COUNT));
      base_ns <= ADDR_W'(ADDR_W'(req.next_state_index) * ADDR_W'(ACTION_COUNT));
    end
  end

  // Row scan: keep the first maximum
  always_ff @(posedge clk) begin
    scan_col_d <= scan_col;
    if (scan_vld) begin
      if (scan_col_d == '0 || scan_val > best) begin
        best   <= scan_val;
        best_a <= scan_col_d;
      end
    end
  end

  // Update datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sqte_pkg::ST_RD_QN: q_reg     <= q_rd;
      sqte_pkg::ST_TD:    td        <= td_next;
      sqte_pkg::ST_WB:    res_value <= nv_sat;
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (req.req_type == sqte_pkg::REQ_UPDATE) begin
        out_data.chosen_action <= '0;
        out_data.explored      <= 1'b0;
        out_data.new_value     <= res_value;
      end else if (req.explore_level > req.random_fraction) begin
        out_data.chosen_action <= ra_mod_tab[req.random_action];
        out_data.explored      <= 1'b1;
        out_data.new_value     <= best;
      end else begin
        out_data.chosen_action <= sqte_pkg::ACT_W'(best_a);
        out_data.explored      <= 1'b0;
        out_data.new_value     <= best;
      end
    end
  end

endmodule

`default_nettype wire
